// ----- src/min_power_sum_terms_macros.svh -----
// Assertion macros shared by the checker of min_power_sum_terms.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef MIN_POWER_SUM_TERMS_MACROS_SVH
`define MIN_POWER_SUM_TERMS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_power_sum_terms check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_power_sum_terms check failed");

`endif

// ----- src/mpst_pkg.sv -----
// Package for min_power_sum_terms: widths, limits, register map and the
// control type passed to the power table builder. No dependencies.
package mpst_pkg;

  localparam int unsigned NUMBER_W       = 16;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned BASE_W         = 8;
  localparam int unsigned POWER_W        = 17;
  localparam int unsigned EXP_W          = 4;
  localparam int unsigned BEST_W         = COUNT_W + 1;
  localparam int unsigned PROD_W         = POWER_W + BASE_W;
  localparam int unsigned TABLE_SIZE     = 65536;
  localparam int unsigned MAX_BASE_COUNT = 256;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [BASE_W-1:0]  BASE_LAST   = BASE_W'(MAX_BASE_COUNT - 1);
  localparam logic [POWER_W-1:0] POWER_CAP   = {POWER_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_CAP   = {COUNT_W{1'b1}};
  localparam logic [BEST_W-1:0]  BEST_INIT   = {BEST_W{1'b1}};

  // Register map, indexed by paddr[2].
  typedef enum logic [0:0] {
    REG_EXPONENT = 1'b0,
    REG_MAX_BASE = 1'b1
  } reg_idx_t;

  localparam logic [EXP_W-1:0]  EXPONENT_RST = EXP_W'(2);
  localparam logic [BASE_W-1:0] MAX_BASE_RST = BASE_W'(255);

  typedef struct packed {
    logic             start;
    logic [EXP_W-1:0] exponent;
  } pwr_ctrl_t;

endpackage

// ----- src/min_power_sum_terms.sv -----
// Top level of min_power_sum_terms: control, count memory and search pipeline.
// Uses mpst_pkg and instantiates mpst_power for the power table.
//
// Usage: numbers 1, 2, 3, ... enter on in_valid/in_stall/in_number, one
// item at a time; in_stall is high while an item is being worked on. Each
// item gives one result on out_valid/out_stall. A number other than the
// expected next one changes nothing; its result, with order_error set, is
// loaded from the finish state once the output register is free. An
// accepted number issues one count memory read per base, from base 1 up
// to max_base but at least base 1, in a pipeline through the power memory
// and the count memory. In both cases the next item can be taken in the
// cycle after the result is loaded. Number 1 first builds the power table
// with the shared multiplier, for all 256 bases.
// A new item may be accepted while the last result still waits in the
// output register; if the receiver stalls, the next result waits in its
// final state and the payload holds. Reset returns the expected number to 1
// and the registers to exponent 2, max_base 255; the count memory needs no
// clearing, as every entry is written before it is read and entry zero
// reads as 0. Configuration goes through the APB port.
module min_power_sum_terms (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mpst_pkg::NUMBER_W-1:0]   in_number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mpst_pkg::NUMBER_W-1:0]   out_number_echo,
  output logic [mpst_pkg::COUNT_W-1:0]    out_min_terms,
  output logic [mpst_pkg::BASE_W-1:0]     out_first_base,
  output logic                            out_saturated,
  output logic                            out_order_error,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpst_pkg::PADDR_W-1:0]    paddr,
  input  logic [mpst_pkg::PDATA_W-1:0]    pwdata,
  output logic [mpst_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_SEARCH,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                        state_r;
  logic [mpst_pkg::EXP_W-1:0]    exponent_r;
  logic [mpst_pkg::BASE_W-1:0]   max_base_r;
  logic [mpst_pkg::NUMBER_W:0]   expected_r;
  logic [mpst_pkg::NUMBER_W-1:0] n_r;
  logic                          err_r;
  logic [mpst_pkg::BASE_W-1:0]   top_r;
  logic [mpst_pkg::BASE_W-1:0]   base_r;
  logic [mpst_pkg::BEST_W-1:0]   best_r;
  logic [mpst_pkg::BASE_W-1:0]   first_r;
  logic                          s1_vld_r;
  logic [mpst_pkg::BASE_W-1:0]   s1_base_r;
  logic                          s2_vld_r;
  logic [mpst_pkg::BASE_W-1:0]   s2_base_r;
  logic                          s2_zero_r;
  logic [mpst_pkg::COUNT_W-1:0]  cnt_q_r;

  logic                          out_valid_r;
  logic [mpst_pkg::NUMBER_W-1:0] out_number_echo_r;
  logic [mpst_pkg::COUNT_W-1:0]  out_min_terms_r;
  logic [mpst_pkg::BASE_W-1:0]   out_first_base_r;
  logic                          out_saturated_r;
  logic                          out_order_error_r;

  logic                          cfg_wr;
  mpst_pkg::reg_idx_t            cfg_idx;
  logic                          in_acc;
  logic                          num_ok;
  mpst_pkg::pwr_ctrl_t           pwr_ctrl;
  logic                          pwr_busy;
  logic [mpst_pkg::POWER_W-1:0]  pwr_rd_data;
  logic [mpst_pkg::POWER_W-1:0]  s1_power;
  logic                          s1_fits;
  logic [mpst_pkg::NUMBER_W-1:0] cnt_raddr;
  logic [mpst_pkg::COUNT_W-1:0]  s2_count;
  logic [mpst_pkg::BEST_W-1:0]   s2_cand;
  logic                          fin_load;
  logic                          cnt_we;
  logic [mpst_pkg::COUNT_W-1:0]  best_sat;

  logic [mpst_pkg::COUNT_W-1:0]  cnt_mem [mpst_pkg::TABLE_SIZE];

  // Configuration port
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mpst_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      mpst_pkg::REG_EXPONENT: prdata = mpst_pkg::PDATA_W'(exponent_r);
      mpst_pkg::REG_MAX_BASE: prdata = mpst_pkg::PDATA_W'(max_base_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= mpst_pkg::EXPONENT_RST;
      max_base_r <= mpst_pkg::MAX_BASE_RST;
    end else if (cfg_wr && pready) begin
      unique case (cfg_idx)
        mpst_pkg::REG_EXPONENT: exponent_r <= pwdata[mpst_pkg::EXP_W-1:0];
        mpst_pkg::REG_MAX_BASE: max_base_r <= pwdata[mpst_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign num_ok   = ({1'b0, in_number} == expected_r);

  assign pwr_ctrl.start    = in_acc && num_ok && (in_number == mpst_pkg::NUMBER_W'(1));
  assign pwr_ctrl.exponent = exponent_r;

  mpst_power u_power (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (pwr_ctrl),
    .busy    (pwr_busy),
    .rd_addr (base_r),
    .rd_data (pwr_rd_data)
  );

  // Stage 1: the power of the base is back; base 1 stands for the
  // candidate built on the number just below.
  assign s1_power  = (s1_base_r == mpst_pkg::BASE_W'(1)) ?
                     mpst_pkg::POWER_W'(1) : pwr_rd_data;
  assign s1_fits   = (s1_power <= {1'b0, n_r});
  assign cnt_raddr = n_r - s1_power[mpst_pkg::NUMBER_W-1:0];

  // Stage 2: entry zero of the count table always reads as zero.
  assign s2_count = s2_zero_r ? '0 : cnt_q_r;
  assign s2_cand  = {1'b0, s2_count} + mpst_pkg::BEST_W'(1);

  assign fin_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
  assign cnt_we   = fin_load && !err_r;
  assign best_sat = best_r[mpst_pkg::COUNT_W] ? mpst_pkg::COUNT_CAP
                                              : best_r[mpst_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[n_r] <= best_sat;
    end
    cnt_q_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expected_r  <= (mpst_pkg::NUMBER_W + 1)'(1);
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !fin_load) begin
        out_valid_r <= 1'b0;
      end

      s1_vld_r  <= (state_r == S_SEARCH);
      s2_vld_r  <= s1_vld_r && s1_fits;
      s2_base_r <= s1_base_r;
      s2_zero_r <= (cnt_raddr == '0);
      // Later bases win ties, since they arrive later in the pipeline.
      if (s2_vld_r && (s2_cand <= best_r)) begin
        best_r  <= s2_cand;
        first_r <= s2_base_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            n_r     <= in_number;
            err_r   <= !num_ok;
            top_r   <= max_base_r;
            base_r  <= mpst_pkg::BASE_W'(1);
            best_r  <= mpst_pkg::BEST_INIT;
            first_r <= mpst_pkg::BASE_W'(1);
            if (!num_ok) begin
              state_r <= S_FINISH;
            end else if (pwr_ctrl.start) begin
              state_r <= S_BUILD;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_BUILD: begin
          if (!pwr_busy) begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          s1_base_r <= base_r;
          if (base_r >= top_r) begin
            state_r <= S_DRAIN;
          end else begin
            base_r <= base_r + mpst_pkg::BASE_W'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_vld_r && !s2_vld_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_load) begin
            out_valid_r       <= 1'b1;
            out_number_echo_r <= n_r;
            out_order_error_r <= err_r;
            if (err_r) begin
              out_min_terms_r  <= '0;
              out_first_base_r <= '0;
              out_saturated_r  <= 1'b0;
            end else begin
              out_min_terms_r  <= best_sat;
              out_first_base_r <= first_r;
              out_saturated_r  <= best_r[mpst_pkg::COUNT_W];
              expected_r       <= expected_r + (mpst_pkg::NUMBER_W + 1)'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_number_echo = out_number_echo_r;
  assign out_min_terms   = out_min_terms_r;
  assign out_first_base  = out_first_base_r;
  assign out_saturated   = out_saturated_r;
  assign out_order_error = out_order_error_r;

endmodule

// ----- src/mpst_power.sv -----
// Power table for min_power_sum_terms: builds b^exponent, saturated at POWER_CAP,
// for every base into a 256-entry memory with one shared multiplier. Uses mpst_pkg.
module mpst_power (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpst_pkg::pwr_ctrl_t           ctrl,
  output logic                          busy,
  input  logic [mpst_pkg::BASE_W-1:0]   rd_addr,
  output logic [mpst_pkg::POWER_W-1:0]  rd_data
);

  logic                         busy_r;
  logic [mpst_pkg::BASE_W-1:0]  base_r;
  logic [mpst_pkg::POWER_W-1:0] acc_r;
  logic [mpst_pkg::EXP_W-1:0]   steps_r;
  logic [mpst_pkg::EXP_W-1:0]   steps_init_r;
  logic [mpst_pkg::EXP_W-1:0]   steps_init;
  logic [mpst_pkg::PROD_W-1:0]  prod;
  logic [mpst_pkg::POWER_W-1:0] prod_sat;
  logic [mpst_pkg::POWER_W-1:0] rd_data_r;
  logic                         wr_en;

  logic [mpst_pkg::POWER_W-1:0] pmem [mpst_pkg::MAX_BASE_COUNT];

  // An exponent of zero builds the table as for exponent one.
  assign steps_init = (ctrl.exponent == '0) ? '0 : ctrl.exponent - mpst_pkg::EXP_W'(1);

  assign prod     = mpst_pkg::PROD_W'(acc_r) * mpst_pkg::PROD_W'(base_r);
  assign prod_sat = (prod > mpst_pkg::PROD_W'(mpst_pkg::POWER_CAP)) ?
                    mpst_pkg::POWER_CAP : prod[mpst_pkg::POWER_W-1:0];
  assign wr_en    = busy_r && (steps_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctrl.start) begin
      busy_r       <= 1'b1;
      base_r       <= '0;
      acc_r        <= '0;
      steps_r      <= steps_init;
      steps_init_r <= steps_init;
    end else if (busy_r) begin
      if (steps_r == '0) begin
        if (base_r == mpst_pkg::BASE_LAST) begin
          busy_r <= 1'b0;
        end else begin
          base_r  <= base_r + mpst_pkg::BASE_W'(1);
          acc_r   <= mpst_pkg::POWER_W'(base_r + mpst_pkg::BASE_W'(1));
          steps_r <= steps_init_r;
        end
      end else begin
        acc_r   <= prod_sat;
        steps_r <= steps_r - mpst_pkg::EXP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pmem[base_r] <= acc_r;
    end
    rd_data_r <= pmem[rd_addr];
  end

  assign busy    = busy_r;
  assign rd_data = rd_data_r;

endmodule

// ----- src/mpst_checker.sv -----
// Port-level checker for min_power_sum_terms, bound to the top level below.
// Depends on min_power_sum_terms_macros.svh and mpst_pkg.
`include "min_power_sum_terms_macros.svh"

module mpst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mpst_pkg::NUMBER_W-1:0] out_number_echo,
  input logic [mpst_pkg::COUNT_W-1:0]  out_min_terms,
  input logic [mpst_pkg::BASE_W-1:0]   out_first_base,
  input logic                          out_saturated,
  input logic                          out_order_error
);

  // A stalled result stays valid and keeps its number echo and count.
  `MPST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_number_echo) && $stable(out_min_terms))

  // Once an item is taken, the block works on it before taking another.
  `MPST_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // A rejected item carries no count, base or saturation flag.
  `MPST_ASSERT_NOW(a_error_empty, out_valid && out_order_error, out_min_terms == '0 && out_first_base == '0 && !out_saturated)

  // An accepted item needs at least one term and names a base.
  `MPST_ASSERT_NOW(a_result_sane, out_valid && !out_order_error, out_min_terms != '0 && out_first_base != '0)

  // Saturation is flagged only with the capped count.
  `MPST_ASSERT_NOW(a_sat_cap, out_valid && out_saturated, out_min_terms == mpst_pkg::COUNT_CAP)

endmodule

bind min_power_sum_terms mpst_checker u_mpst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_number_echo (out_number_echo),
  .out_min_terms   (out_min_terms),
  .out_first_base  (out_first_base),
  .out_saturated   (out_saturated),
  .out_order_error (out_order_error)
);
